[rtl/qvb_pkg.sv]
// shared types, constants and helper functions of the quad vertex generator
package qvb_pkg;

  localparam logic [2:0] OP_SPRITE = 3'd0;
  localparam logic [2:0] OP_RECT   = 3'd1;
  localparam logic [2:0] OP_LINE   = 3'd2;
  localparam logic [2:0] OP_BEGIN  = 3'd3;
  localparam logic [2:0] OP_END    = 3'd4;

  localparam logic [11:0] THRESHOLD_RESET = 12'd1000;
  // index count 3/2*n passes 3000 exactly when n passes 2000
  localparam int unsigned INDEX_FLUSH = 2000;
  localparam logic signed [19:0] GAIN_Q16 = 20'sd39797;
  localparam int unsigned ATAN_LEN = 24;

  typedef enum logic [1:0] {
    K_SPRITE,
    K_RECT,
    K_LINE,
    K_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] ex;
    logic signed [23:0] ey;
    logic [15:0]        tl;
    logic [15:0]        tt;
    logic [15:0]        tw;
    logic [15:0]        th;
    logic signed [15:0] angle;
    logic [15:0]        lw;
    logic [31:0]        color;
  } item_t;

  // arctangent in 2^-24 turn units, rounded
  function automatic logic signed [25:0] atan_at(input logic [4:0] i);
    logic signed [25:0] r;
    unique case (i)
      5'd0:  r = 26'sd2097152;
      5'd1:  r = 26'sd1238021;
      5'd2:  r = 26'sd654136;
      5'd3:  r = 26'sd332050;
      5'd4:  r = 26'sd166669;
      5'd5:  r = 26'sd83416;
      5'd6:  r = 26'sd41718;
      5'd7:  r = 26'sd20860;
      5'd8:  r = 26'sd10430;
      5'd9:  r = 26'sd5215;
      5'd10: r = 26'sd2608;
      5'd11: r = 26'sd1304;
      5'd12: r = 26'sd652;
      5'd13: r = 26'sd326;
      5'd14: r = 26'sd163;
      5'd15: r = 26'sd81;
      5'd16: r = 26'sd41;
      5'd17: r = 26'sd20;
      5'd18: r = 26'sd10;
      5'd19: r = 26'sd5;
      5'd20: r = 26'sd3;
      5'd21: r = 26'sd1;
      5'd22: r = 26'sd1;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [43:0] v);
    logic signed [23:0] r;
    if (v > 44'sd8388607) r = 24'sh7FFFFF;
    else if (v < -44'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

[rtl/qvb_if.sv]
// channel interfaces: primitive items, vertices and the threshold write port
interface qvb_item_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic signed [23:0] extent_x;
  logic signed [23:0] extent_y;
  logic [15:0]        tex_left;
  logic [15:0]        tex_top;
  logic [15:0]        tex_width;
  logic [15:0]        tex_height;
  logic signed [15:0] angle;
  logic [15:0]        line_width;
  logic [31:0]        color;
  modport source (output valid, op, point_x, point_y, extent_x, extent_y, tex_left,
                  tex_top, tex_width, tex_height, angle, line_width, color,
                  input ready);
  modport sink (input valid, op, point_x, point_y, extent_x, extent_y, tex_left,
                tex_top, tex_width, tex_height, angle, line_width, color,
                output ready);
endinterface

interface qvb_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] vert_x;
  logic signed [23:0] vert_y;
  logic [16:0]        vert_u;
  logic [16:0]        vert_v;
  logic [31:0]        vert_color;
  logic [11:0]        vert_index;
  logic               flushed;
  logic               overflow;
  logic               last;
  modport source (output valid, vert_x, vert_y, vert_u, vert_v, vert_color, vert_index,
                  flushed, overflow, last, input ready);
  modport sink (input valid, vert_x, vert_y, vert_u, vert_v, vert_color, vert_index,
                flushed, overflow, last, output ready);
endinterface

interface qvb_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[rtl/qvb_front.sv]
// front stage: accepts items, classifies the op code and drops unused codes
module qvb_front (
  input  logic          clk,
  input  logic          rst,
  qvb_item_if.sink      item,
  output logic          push_valid,
  input  logic          push_ready,
  output qvb_pkg::item_t push_item
);
  import qvb_pkg::*;

  logic  held;
  item_t slot;
  kind_t kind_in;
  logic  known;

  assign item.ready = !held || push_ready;
  assign push_valid = held;
  assign push_item  = slot;

  always_comb begin
    known   = 1'b1;
    kind_in = K_CLEAR;
    unique case (item.op)
      OP_SPRITE: kind_in = K_SPRITE;
      OP_RECT:   kind_in = K_RECT;
      OP_LINE:   kind_in = K_LINE;
      OP_BEGIN,
      OP_END:    kind_in = K_CLEAR;
      default:   known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      if (item.valid && item.ready && known) held <= 1'b1;
      else if (push_ready) held <= 1'b0;
      if (item.valid && item.ready && known) begin
        slot.kind   <= kind_in;
        slot.px     <= item.point_x;
        slot.py     <= item.point_y;
        slot.ex     <= item.extent_x;
        slot.ey     <= item.extent_y;
        slot.tl     <= item.tex_left;
        slot.tt     <= item.tex_top;
        slot.tw     <= item.tex_width;
        slot.th     <= item.tex_height;
        slot.angle  <= item.angle;
        slot.lw     <= item.line_width;
        slot.color  <= item.color;
      end
    end
  end

endmodule

[rtl/qvb_fifo.sv]
// short queue of classified items between front and back
module qvb_fifo #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  qvb_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output qvb_pkg::item_t pop_item
);
  import qvb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != CW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = mem[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        mem[wptr] <= push_item;
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (do_push && !do_pop) fill <= fill + 1'b1;
      else if (!do_push && do_pop) fill <= fill - 1'b1;
    end
  end

endmodule

[rtl/qvb_back.sv]
// back end: cordic, square root, divider, vertex sequencer and batch count
module qvb_back #(
  parameter int BATCH_CAPACITY = 4096,
  parameter int CORDIC_STEPS   = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  qvb_pkg::item_t pop_item,
  qvb_cfg_if.sink        cfg,
  qvb_vertex_if.source   vertex
);
  import qvb_pkg::*;

  localparam int CNTW  = $clog2(BATCH_CAPACITY + 1);
  localparam int CMPW  = (CNTW + 1 > 12) ? CNTW + 1 : 12;
  localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  typedef enum logic [3:0] {
    S_IDLE, S_CORDIC, S_SQ, S_SQRT, S_DLOAD, S_DIV, S_MUL, S_RND, S_POS, S_OUT
  } state_t;

  state_t             state;
  item_t              it;
  logic [11:0]        thr;
  logic [CNTW-1:0]    count;
  logic               flush_r;
  logic               rot;
  logic [1:0]         k;
  logic [1:0]         mstep;
  logic [5:0]         cnt;
  logic signed [24:0] cx, cy, dx, dy;
  logic signed [23:0] hx, hy;
  logic signed [19:0] cr_x, cr_y, cosv, sinv;
  logic signed [25:0] cr_z;
  logic               cr_neg;
  logic signed [45:0] accx, accy;
  logic [49:0]        sq_n, sq_r, sq_bit;
  logic [26:0]        den;
  logic [40:0]        dnum, dq;
  logic [26:0]        drem;
  logic               dneg, dsel;
  logic signed [41:0] nx, ny;
  logic signed [23:0] vx, vy;

  // combinational helpers
  logic signed [19:0] cn_x, cn_y;
  logic signed [25:0] cn_z;
  logic signed [15:0] a_fold;
  logic               a_neg;
  logic [CNTW:0]      fin;
  logic               flush_calc;
  logic signed [24:0] ox, oy;
  logic [49:0]        sq_try;
  logic [27:0]        rem_sh;
  logic               qbit;
  logic [40:0]        q_final;
  logic signed [41:0] dprod;
  logic signed [16:0] wsig;

  assign pop_ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    a_neg  = 1'b0;
    a_fold = pop_item.angle;
    if (pop_item.angle > 16'sd16384) begin
      a_fold = pop_item.angle - 16'sd32768;
      a_neg  = 1'b1;
    end else if (pop_item.angle < -16'sd16384) begin
      a_fold = pop_item.angle + 16'sd32768;
      a_neg  = 1'b1;
    end
  end

  // batch size after the four vertices of the item at the queue head
  always_comb begin
    if ((CNTW + 1)'(count) + (CNTW + 1)'(4) > (CNTW + 1)'(BATCH_CAPACITY))
      fin = (count < CNTW'(BATCH_CAPACITY)) ? (CNTW + 1)'(BATCH_CAPACITY)
                                            : (CNTW + 1)'(count);
    else
      fin = (CNTW + 1)'(count) + (CNTW + 1)'(4);
    flush_calc = (CMPW'(fin) > CMPW'(thr)) || (CMPW'(fin) > CMPW'(INDEX_FLUSH));
  end

  always_comb begin
    if (cr_z >= 0) begin
      cn_x = cr_x - (cr_y >>> cnt[4:0]);
      cn_y = cr_y + (cr_x >>> cnt[4:0]);
      cn_z = cr_z - atan_at(cnt[4:0]);
    end else begin
      cn_x = cr_x + (cr_y >>> cnt[4:0]);
      cn_y = cr_y - (cr_x >>> cnt[4:0]);
      cn_z = cr_z + atan_at(cnt[4:0]);
    end
  end

  assign ox = k[0] ? 25'(it.ex) - 25'(hx) : -25'(hx);
  assign oy = k[1] ? 25'(it.ey) - 25'(hy) : -25'(hy);

  assign sq_try = sq_r + sq_bit;
  assign rem_sh = {drem, dnum[40]};
  assign qbit   = (rem_sh >= {1'b0, den});
  assign q_final = {dq[39:0], qbit};
  assign wsig   = $signed({1'b0, it.lw});
  assign dprod  = dsel ? 42'(dx * wsig) : -42'(dy * wsig);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      thr          <= THRESHOLD_RESET;
      vertex.valid <= 1'b0;
    end else begin
      if (cfg.valid) thr <= cfg.data;
      if (vertex.valid && vertex.ready && state != S_OUT) vertex.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            it      <= pop_item;
            k       <= 2'd0;
            mstep   <= 2'd0;
            dsel    <= 1'b0;
            flush_r <= 1'b0;
            rot     <= 1'b0;
            hx      <= pop_item.ex >>> 1;
            hy      <= pop_item.ey >>> 1;
            cx      <= 25'(pop_item.px) + 25'(pop_item.ex >>> 1);
            cy      <= 25'(pop_item.py) + 25'(pop_item.ey >>> 1);
            dx      <= 25'(pop_item.ex) - 25'(pop_item.px);
            dy      <= 25'(pop_item.ey) - 25'(pop_item.py);
            unique case (pop_item.kind)
              K_CLEAR: count <= '0;
              K_SPRITE: begin
                flush_r <= flush_calc;
                if (pop_item.angle != 16'sd0) begin
                  rot    <= 1'b1;
                  cr_x   <= GAIN_Q16;
                  cr_y   <= 20'sd0;
                  cr_z   <= 26'(a_fold) <<< 8;
                  cr_neg <= a_neg;
                  cnt    <= '0;
                  state  <= S_CORDIC;
                end else begin
                  state <= S_POS;
                end
              end
              K_RECT: state <= S_POS;
              K_LINE: state <= S_SQ;
            endcase
          end
        end
        S_CORDIC: begin
          cr_x <= cn_x;
          cr_y <= cn_y;
          cr_z <= cn_z;
          cnt  <= cnt + 1'b1;
          if (cnt == 6'(STEPS - 1)) begin
            cosv  <= cr_neg ? -cn_x : cn_x;
            sinv  <= cr_neg ? -cn_y : cn_y;
            mstep <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          mstep <= mstep + 1'b1;
          unique case (mstep)
            2'd0: accx <= 46'(ox * cosv);
            2'd1: accx <= accx - 46'(oy * sinv);
            2'd2: accy <= 46'(ox * sinv);
            2'd3: begin
              accy  <= accy + 46'(oy * cosv);
              state <= S_RND;
            end
          endcase
        end
        S_RND: begin
          vx    <= sat24(44'((accx + 46'sd32768) >>> 16) + 44'(cx));
          vy    <= sat24(44'((accy + 46'sd32768) >>> 16) + 44'(cy));
          state <= S_OUT;
        end
        S_SQ: begin
          mstep <= mstep + 1'b1;
          if (mstep == 2'd0) begin
            sq_n <= $unsigned(50'(dx * dx));
          end else begin
            sq_n   <= sq_n + $unsigned(50'(dy * dy));
            sq_r   <= '0;
            sq_bit <= 50'd1 << 48;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_n >= sq_try) begin
            sq_n <= sq_n - sq_try;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) state <= S_DLOAD;
        end
        S_DLOAD: begin
          if (sq_r == '0) begin
            // zero-length line: no normal
            nx    <= '0;
            ny    <= '0;
            state <= S_POS;
          end else begin
            den   <= {sq_r[25:0], 1'b0};
            dneg  <= dprod < 0;
            dnum  <= (dprod < 0) ? 41'(-dprod) : 41'(dprod);
            drem  <= '0;
            dq    <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          drem <= qbit ? 27'(rem_sh - {1'b0, den}) : rem_sh[26:0];
          dnum <= dnum << 1;
          dq   <= q_final;
          cnt  <= cnt + 1'b1;
          if (cnt == 6'd40) begin
            if (dsel) begin
              ny    <= dneg ? -42'(q_final) : 42'(q_final);
              state <= S_POS;
            end else begin
              nx    <= dneg ? -42'(q_final) : 42'(q_final);
              dsel  <= 1'b1;
              state <= S_DLOAD;
            end
          end
        end
        S_POS: begin
          if (it.kind == K_LINE) begin
            vx <= sat24(44'(k[0] ? it.ex : it.px) + (k[1] ? -44'(nx) : 44'(nx)));
            vy <= sat24(44'(k[0] ? it.ey : it.py) + (k[1] ? -44'(ny) : 44'(ny)));
          end else begin
            // unrotated sprite corners coincide with the rectangle corners
            vx <= sat24(44'(it.px) + (k[0] ? 44'(it.ex) : 44'sd0));
            vy <= sat24(44'(it.py) + (k[1] ? 44'(it.ey) : 44'sd0));
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!vertex.valid || vertex.ready) begin
            vertex.valid      <= 1'b1;
            vertex.vert_x     <= vx;
            vertex.vert_y     <= vy;
            vertex.vert_color <= it.color;
            vertex.flushed    <= flush_r;
            vertex.last       <= (k == 2'd3);
            if (it.kind == K_SPRITE) begin
              vertex.vert_u <= 17'(it.tl) + (k[0] ? 17'(it.tw) : 17'd0);
              vertex.vert_v <= 17'(it.tt) + (k[1] ? 17'(it.th) : 17'd0);
            end else begin
              vertex.vert_u <= '0;
              vertex.vert_v <= '0;
            end
            if (count < CNTW'(BATCH_CAPACITY)) begin
              vertex.vert_index <= 12'(count);
              vertex.overflow   <= 1'b0;
            end else begin
              vertex.vert_index <= '0;
              vertex.overflow   <= 1'b1;
            end
            // a flush after the last vertex clears the batch
            if (k == 2'd3 && flush_r) count <= '0;
            else if (count < CNTW'(BATCH_CAPACITY)) count <= count + 1'b1;
            if (k == 2'd3) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              mstep <= 2'd0;
              state <= rot ? S_MUL : S_POS;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(BATCH_CAPACITY))
    else $error("batch count beyond capacity");

  a_ovf_index: assert property (@(posedge clk) disable iff (rst)
    vertex.valid && vertex.overflow |-> vertex.vert_index == '0)
    else $error("overflowed vertex carries an index");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && k == 2'd3 && flush_r && (!vertex.valid || vertex.ready)
    |=> count == '0)
    else $error("flush did not clear the batch");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop_valid && pop_ready |=> state != S_IDLE || it.kind == K_CLEAR)
    else $error("primitive popped without work");

endmodule

[rtl/quad_vertex_batch_generator.sv]
// top level of the quad vertex batch generator
// Usage:
//   item: one primitive or frame command per beat (valid/ready). sprite, rectangle
//   and line each give four vertex beats on vertex; begin and end of frame clear
//   the batch count and give none; unused op codes are dropped.
//   cfg: write of flush_threshold, always ready; write only while idle.
// Sequence per item after it reaches the back end:
//   rectangle or unrotated sprite: a position step, then output, per vertex.
//   rotated sprite: CORDIC iterations, then per vertex four multiply passes,
//   a round step and output.
//   line: squaring of dx and dy, 25 square root steps, two 41-step divisions
//   with a load state each, then a position step and output per vertex.
//   The back end works on one item at a time; the front stage and a short
//   queue keep taking items while it is busy.
// Reset: batch count zero, threshold 1000, queue empty, no vertex shown.
// Stall: a vertex is held in the output register until taken; the back end
//   waits and the queue fills, then item.ready falls.
module quad_vertex_batch_generator #(
  parameter int BATCH_CAPACITY = 4096,
  parameter int CORDIC_STEPS   = 16,
  parameter int QUEUE_DEPTH    = 2
) (
  input logic          clk,
  input logic          rst,
  qvb_item_if.sink     item,
  qvb_vertex_if.source vertex,
  qvb_cfg_if.sink      cfg
);
  import qvb_pkg::*;

  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  qvb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  qvb_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  qvb_back #(
    .BATCH_CAPACITY (BATCH_CAPACITY),
    .CORDIC_STEPS   (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .cfg       (cfg),
    .vertex    (vertex)
  );

endmodule
